### design/vhcm_pkg.sv
// ----------------------------------------------------------------------------
// vhcm_pkg: shared types and constants of the value to hue color mapper
// constants, register indexes and the pipeline stage control struct
// ----------------------------------------------------------------------------
package vhcm_pkg;

    localparam int SampleWidthDefault = 32;
    localparam int ColorWidthDefault  = 16;
    localparam int LevelWidth         = 16;
    localparam int RegIndexWidth      = 3;
    localparam int FracBits           = 16;

    localparam logic [15:0] HueThird = 16'd21845;

    typedef enum logic [RegIndexWidth-1:0] {
        REG_VALUE_BEGIN = 3'd0,
        REG_VALUE_END   = 3'd1,
        REG_HUE_BEGIN   = 3'd2,
        REG_HUE_END     = 3'd3,
        REG_SATURATION  = 3'd4,
        REG_LIGHTNESS   = 3'd5
    } t_reg_index;

    // per-stage control that travels with the data
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctrl;

endpackage

### design/vhcm_stream_if.sv
// ----------------------------------------------------------------------------
// vhcm_stream_if: valid/ready channel
// carries one item per accepted handshake
// ----------------------------------------------------------------------------
interface vhcm_stream_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/vhcm_divider.sv
// ----------------------------------------------------------------------------
// vhcm_divider: pipelined fraction divider
// computes floor(2^16 * n / d) for n < d, four quotient bits per stage
// ----------------------------------------------------------------------------
module vhcm_divider
    import vhcm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SampleWidthDefault,
    parameter int TAG_WIDTH    = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic                    i_valid,
    input  logic [SAMPLE_WIDTH:0]   i_num,
    input  logic [SAMPLE_WIDTH:0]   i_den,
    input  logic [TAG_WIDTH-1:0]    i_tag,
    output logic                    o_valid,
    output logic [FracBits-1:0]     o_quot,
    output logic [TAG_WIDTH-1:0]    o_tag
);

    localparam int Stages    = 4;
    localparam int BitsPerSt = FracBits / Stages;
    localparam int MagWidth  = SAMPLE_WIDTH + 1;

    logic [Stages-1:0]    r_valid;
    logic [MagWidth-1:0]  r_rem  [Stages];
    logic [MagWidth-1:0]  r_den  [Stages];
    logic [FracBits-1:0]  r_quot [Stages];
    logic [TAG_WIDTH-1:0] r_tag  [Stages];

    logic [MagWidth-1:0]  n_rem  [Stages];
    logic [FracBits-1:0]  n_quot [Stages];

    always_comb begin
        logic [MagWidth:0]   wide;
        logic [MagWidth-1:0] rem;
        logic [MagWidth-1:0] den;
        logic [FracBits-1:0] q;
        for (int s = 0; s < Stages; s++) begin
            rem = (s == 0) ? i_num : r_rem[(s == 0) ? 0 : s-1];
            den = (s == 0) ? i_den : r_den[(s == 0) ? 0 : s-1];
            q   = (s == 0) ? '0 : r_quot[(s == 0) ? 0 : s-1];
            for (int b = 0; b < BitsPerSt; b++) begin
                wide = {rem, 1'b0};
                q    = {q[FracBits-2:0], 1'b0};
                if (wide >= {1'b0, den}) begin
                    wide = wide - {1'b0, den};
                    q[0] = 1'b1;
                end
                rem = wide[MagWidth-1:0];
            end
            n_rem[s]  = rem;
            n_quot[s] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_advance) begin
            r_valid <= {r_valid[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int s = 0; s < Stages; s++) begin
                r_rem[s]  <= n_rem[s];
                r_quot[s] <= n_quot[s];
                r_den[s]  <= (s == 0) ? i_den : r_den[(s == 0) ? 0 : s-1];
                r_tag[s]  <= (s == 0) ? i_tag : r_tag[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign o_valid = r_valid[Stages-1];
    assign o_quot  = r_quot[Stages-1];
    assign o_tag   = r_tag[Stages-1];

`ifndef SYNTHESIS
    // remainder stays below the divisor for valid items
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[Stages-1] |-> (r_rem[Stages-1] < r_den[Stages-1]))
        else $error("divider remainder not below divisor");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_advance) |-> $stable(r_valid))
        else $error("divider valid bits moved while stalled");
    a_quot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_advance) |-> $stable(o_quot))
        else $error("divider quotient moved while stalled");
`endif

endmodule

### design/value_to_hue_color_mapper.sv
// ----------------------------------------------------------------------------
// value_to_hue_color_mapper: linear hue color map with hsl to rgb
// maps a signed sample onto a hue span and converts it to an rgb color
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  i_sample  sink       sample_value
//  o_color   source     red_level, green_level, blue_level
//  cfg       write      i_cfg_we, i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; an item passes through
// 1 compare stage, 4 divider stages, hue multiply, lightness terms, channel
// multiply, output register. reset clears valid bits and sets config registers to defaults.
// a stall on the output freezes the whole pipeline, no item lost or repeated.
module value_to_hue_color_mapper
    import vhcm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SampleWidthDefault,
    parameter int COLOR_WIDTH  = ColorWidthDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    vhcm_stream_if.sink              i_sample,
    vhcm_stream_if.source            o_color,
    input  logic                     i_cfg_we,
    input  logic [RegIndexWidth-1:0] i_cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]  i_cfg_data
);

    localparam int MagWidth = SAMPLE_WIDTH + 1;
    localparam int LW       = LevelWidth;

    // configuration
    logic signed [SAMPLE_WIDTH-1:0] r_value_begin, r_value_end;
    logic [LW-1:0] r_hue_begin, r_hue_end, r_sat, r_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_begin <= '0;
            r_value_end   <= '0;
            r_hue_begin   <= '0;
            r_hue_end     <= 16'd43690;
            r_sat         <= 16'd65535;
            r_light       <= 16'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_VALUE_BEGIN: r_value_begin <= i_cfg_data;
                REG_VALUE_END:   r_value_end   <= i_cfg_data;
                REG_HUE_BEGIN:   r_hue_begin   <= i_cfg_data[LW-1:0];
                REG_HUE_END:     r_hue_end     <= i_cfg_data[LW-1:0];
                REG_SATURATION:  r_sat         <= i_cfg_data[LW-1:0];
                REG_LIGHTNESS:   r_light       <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // global stall: output register moves when empty or taken
    logic w_advance;
    logic r_out_valid;
    assign w_advance      = !r_out_valid || o_color.ready;
    assign i_sample.ready = w_advance;

    t_stage_ctrl w_in;
    assign w_in.valid   = i_sample.valid;
    assign w_in.advance = w_advance;

    // stage 1: sign compare and magnitudes
    logic r1_valid;
    logic [MagWidth-1:0] r1_num, r1_den;
    logic [1:0] r1_force; // bit1: forced, bit0: forced value is one

    logic signed [SAMPLE_WIDTH-1:0] w_sv;
    logic signed [MagWidth-1:0] w_sv_x, w_vb_x, w_ve_x, w_dsv, w_dve;
    logic w_up;
    logic [MagWidth-1:0] w_nmag, w_dmag;
    logic [1:0] n1_force;

    always_comb begin
        w_sv   = i_sample.data;
        w_sv_x = MagWidth'(w_sv);
        w_vb_x = MagWidth'(r_value_begin);
        w_ve_x = MagWidth'(r_value_end);
        w_up   = r_value_begin < r_value_end;
        w_dsv  = w_sv_x - w_vb_x;
        w_dve  = w_ve_x - w_vb_x;
        w_nmag = w_up ? w_dsv : -w_dsv;
        w_dmag = w_up ? w_dve : -w_dve;
        if (r_value_end == r_value_begin) begin
            n1_force = {1'b1, !(w_sv < r_value_begin)};
        end else if (w_sv == r_value_begin || ((r_value_begin < w_sv) != w_up)) begin
            n1_force = 2'b10;
        end else if (w_nmag >= w_dmag) begin
            n1_force = 2'b11;
        end else begin
            n1_force = 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_in.advance) begin
            r1_valid <= w_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in.advance) begin
            r1_force <= n1_force;
            // forced items run the divider on a harmless 0/1
            r1_num   <= n1_force[1] ? '0 : w_nmag;
            r1_den   <= n1_force[1] ? MagWidth'(1) : w_dmag;
        end
    end

    // stages 2..5: divider
    logic d_valid;
    logic [FracBits-1:0] d_quot;
    logic [1:0] d_force;

    vhcm_divider #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TAG_WIDTH    (2)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (r1_valid),
        .i_num     (r1_num),
        .i_den     (r1_den),
        .i_tag     (r1_force),
        .o_valid   (d_valid),
        .o_quot    (d_quot),
        .o_tag     (d_force)
    );

    // stage 6: hue
    logic [FracBits:0] w_ratio;
    logic [LW-1:0] w_hspan;
    logic [FracBits+LW:0] w_hprod;
    logic r6_valid;
    logic [LW-1:0] r6_hue;

    always_comb begin
        w_ratio = d_force[1] ? {d_force[0], {FracBits{1'b0}}} : {1'b0, d_quot};
        w_hspan = r_hue_end - r_hue_begin;
        w_hprod = w_ratio * w_hspan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_advance) begin
            r6_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r6_hue <= (r_hue_end <= r_hue_begin) ? r_hue_begin
                    : r_hue_begin + w_hprod[FracBits+LW-1:FracBits];
        end
    end

    // stage 7: hsl terms (the user keeps config static while items flow; the block has no check for it)
    logic [2*LW:0] w_ls;
    logic [LW+1:0] w_t2, w_t1, w_2l;
    logic r7_valid;
    logic [LW-1:0] r7_hue;
    logic [LW:0] r7_t1, r7_t2;

    always_comb begin
        w_ls = r_light * {1'b1, r_sat}; // L*(65536+S)
        if (!r_light[LW-1]) begin
            w_t2 = (LW+2)'(w_ls[2*LW:LW]);
        end else begin
            // L + S - floor(L*S/65536), where floor(L*S/65536) is the high half of L*(65536+S) minus L
            w_t2 = (LW+2)'(r_light) + (LW+2)'(r_sat)
                 - (LW+2)'(w_ls[2*LW:LW] - (LW+1)'(r_light));
        end
        w_2l = {1'b0, r_light, 1'b0};
        w_t1 = (w_2l >= w_t2) ? w_2l - w_t2 : '0;
        if (w_t1 > w_t2) w_t1 = w_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_advance) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r7_hue <= r6_hue;
            r7_t1  <= w_t1[LW:0];
            r7_t2  <= w_t2[LW:0];
        end
    end

    // stage 8: channel multiplies
    logic [LW-1:0] w_ch_hue [3];
    logic [LW:0]   w_span;
    logic [1:0]    r8_sel [3];
    logic [2*LW+3:0] r8_prod [3];
    logic [LW:0]   r8_t1, r8_t2;
    logic r8_valid;

    always_comb begin
        w_ch_hue[0] = r7_hue + HueThird;
        w_ch_hue[1] = r7_hue;
        w_ch_hue[2] = r7_hue - HueThird;
        w_span      = r7_t2 - r7_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (w_advance) begin
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [LW+2:0] t6;
        if (w_advance) begin
            r8_t1 <= r7_t1;
            r8_t2 <= r7_t2;
            for (int c = 0; c < 3; c++) begin
                t6 = (LW+3)'(w_ch_hue[c]) * 3'd6;
                if (t6 < (LW+3)'(65536)) begin
                    r8_sel[c]  <= 2'd0;
                    r8_prod[c] <= w_span * t6;
                end else if (w_ch_hue[c] < 16'd32768) begin
                    r8_sel[c]  <= 2'd1;
                    r8_prod[c] <= '0;
                end else if ((LW+3)'(w_ch_hue[c]) * 3'd3 < (LW+3)'(131072)) begin
                    r8_sel[c]  <= 2'd0;
                    r8_prod[c] <= w_span * ((LW+3)'(262144) - t6);
                end else begin
                    r8_sel[c]  <= 2'd2;
                    r8_prod[c] <= '0;
                end
            end
        end
    end

    // stage 9: output register
    logic [COLOR_WIDTH-1:0] r_out [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [LW+4:0] v;
        if (w_advance) begin
            for (int c = 0; c < 3; c++) begin
                case (r8_sel[c])
                    2'd0:    v = (LW+5)'(r8_t1) + (LW+5)'(r8_prod[c][2*LW+3:LW]);
                    2'd1:    v = (LW+5)'(r8_t2);
                    default: v = (LW+5)'(r8_t1);
                endcase
                if (v > (LW+5)'(65535)) v = (LW+5)'(65535);
                r_out[c] <= v[LW-1 -: COLOR_WIDTH];
            end
        end
    end

    assign o_color.valid = r_out_valid;
    assign o_color.data  = {r_out[0], r_out[1], r_out[2]};

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_color.valid && !o_color.ready) |=> (o_color.valid && $stable(o_color.data)))
        else $error("output item changed while stalled");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_sample.ready)
        else $error("input blocked with empty output");
    a_hue_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_valid && r_hue_begin < r_hue_end) |->
        (r6_hue >= r_hue_begin && r6_hue <= r_hue_end))
        else $error("hue outside span");
`endif

endmodule
